[rtl/pspc_pkg.sv]
// Shared types, register map and helpers for the pedal sensor plausibility block.
package pspc_pkg;

    localparam int unsigned SAMPLE_W = 12;
    localparam int unsigned FRAC_W   = 8;
    localparam int unsigned PADDR_W  = 5;
    localparam int unsigned PDATA_W  = 32;
    localparam int unsigned REG_IDX_W = 3;
    localparam int unsigned IN_TDATA_W  = 64;
    localparam int unsigned OUT_TDATA_W = 48;
    localparam int unsigned PROD_W   = SAMPLE_W + FRAC_W;

    // register indexes (byte address is 4 * index)
    localparam logic [REG_IDX_W-1:0] REG_THR_SPIKE   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_BRK_SPIKE   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_THR_PRESSED = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_BRK_PRESSED = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_THR_FRAC    = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_BRK_FRAC    = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_OVL_THR     = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_OVL_BRK     = 3'd7;

    localparam logic [SAMPLE_W-1:0] RST_THR_SPIKE   = 12'd400;
    localparam logic [SAMPLE_W-1:0] RST_BRK_SPIKE   = 12'd400;
    localparam logic [SAMPLE_W-1:0] RST_THR_PRESSED = 12'd200;
    localparam logic [SAMPLE_W-1:0] RST_BRK_PRESSED = 12'd200;
    localparam logic [FRAC_W-1:0]   RST_THR_FRAC    = 8'd26;
    localparam logic [FRAC_W-1:0]   RST_BRK_FRAC    = 8'd26;
    localparam logic [SAMPLE_W-1:0] RST_OVL_THR     = 12'd1024;
    localparam logic [SAMPLE_W-1:0] RST_OVL_BRK     = 12'd800;

    typedef struct packed {
        logic [SAMPLE_W-1:0] throttle_spike_limit;
        logic [SAMPLE_W-1:0] brake_spike_limit;
        logic [SAMPLE_W-1:0] throttle_pressed_level;
        logic [SAMPLE_W-1:0] brake_pressed_level;
        logic [FRAC_W-1:0]   throttle_mismatch_frac;
        logic [FRAC_W-1:0]   brake_mismatch_frac;
        logic [SAMPLE_W-1:0] overlap_throttle_level;
        logic [SAMPLE_W-1:0] overlap_brake_level;
    } t_cfg;

    // filtered sample set, front to back
    typedef struct packed {
        logic                bspd;
        logic [SAMPLE_W-1:0] cur;
        logic [SAMPLE_W-1:0] bb;
        logic [SAMPLE_W-1:0] ba;
        logic [SAMPLE_W-1:0] tb;
        logic [SAMPLE_W-1:0] ta;
    } t_filt;

    // result item, packed highest field first
    typedef struct packed {
        logic                fault_latching;
        logic                fault_recoverable;
        logic                overlap_fault;
        logic                bspd_fault;
        logic                brake_mismatch;
        logic                throttle_mismatch;
        logic                brake_pressed;
        logic                throttle_pressed;
        logic [SAMPLE_W-1:0] current_out;
        logic [SAMPLE_W-1:0] brake_avg;
        logic [SAMPLE_W-1:0] throttle_avg;
    } t_result;

    // queue status, queue to front and back
    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    function automatic logic [SAMPLE_W-1:0] abs_diff(
        input logic [SAMPLE_W-1:0] x,
        input logic [SAMPLE_W-1:0] y
    );
        return (x > y) ? (x - y) : (y - x);
    endfunction

endpackage

[rtl/pedal_sensor_plausibility_top.sv]
// Pedal sensor plausibility check: top level wiring front, queue, back and registers.
// An accepted item is written into the queue, then loaded into the back stage's output register.
// Throughput: one item per cycle while the output is not stalled; front filter and back-stage checks are combinational.
// The two-entry queue lets the front keep accepting while a result waits on the output.
// Reset (synchronous, active low) clears queue, output valid, stored samples to zero,
// and loads all thresholds with their defaults.
module pedal_sensor_plausibility_top #(
    parameter int unsigned CURRENT_SPIKE_LIMIT = 400
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // slave side: sample sets
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [11:0] throttle_raw_a, [23:12] throttle_raw_b, [35:24] brake_raw_a,
    // [47:36] brake_raw_b, [59:48] current_raw, [60] bspd_line_low, [63:61] zero
    input  logic [pspc_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // master side: results
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [11:0] throttle_avg, [23:12] brake_avg, [35:24] current_out,
    // [36] throttle_pressed, [37] brake_pressed, [38] throttle_mismatch,
    // [39] brake_mismatch, [40] bspd_fault, [41] overlap_fault,
    // [42] fault_recoverable, [43] fault_latching, [47:44] zero
    output logic [pspc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // configuration
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [pspc_pkg::PADDR_W-1:0]     paddr,
    input  logic [pspc_pkg::PDATA_W-1:0]     pwdata,
    output logic [pspc_pkg::PDATA_W-1:0]     prdata,
    output logic                             pready
);

    pspc_pkg::t_cfg   w_cfg;
    pspc_pkg::t_filt  w_push_filt;
    pspc_pkg::t_filt  w_head_filt;
    pspc_pkg::t_qstat w_qstat;
    logic             w_push;
    logic             w_pop;

    // no wait states on the register port
    assign pready = 1'b1;

    pspc_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_cfg     (w_cfg)
    );

    // front: spike filter; stored samples move only on an accepted item
    pspc_front #(
        .CURRENT_SPIKE_LIMIT (CURRENT_SPIKE_LIMIT)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_data  (s_axis_tdata),
        .i_cfg   (w_cfg),
        .i_qstat (w_qstat),
        .o_push  (w_push),
        .o_filt  (w_push_filt)
    );

    // decouples front from an output stall
    pspc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_filt  (w_push_filt),
        .i_pop   (w_pop),
        .o_filt  (w_head_filt),
        .o_qstat (w_qstat)
    );

    // back: checks and output register
    pspc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_filt  (w_head_filt),
        .i_avail (!w_qstat.empty),
        .o_pop   (w_pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (m_axis_tdata)
    );

endmodule

[rtl/pspc_regs.sv]
// APB register file holding the plausibility thresholds.
module pspc_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_psel,
    input  logic                          i_penable,
    input  logic                          i_pwrite,
    input  logic [pspc_pkg::PADDR_W-1:0]  i_paddr,
    input  logic [pspc_pkg::PDATA_W-1:0]  i_pwdata,
    output logic [pspc_pkg::PDATA_W-1:0]  o_prdata,
    output pspc_pkg::t_cfg                o_cfg
);

    pspc_pkg::t_cfg r_cfg;
    pspc_pkg::t_cfg n_cfg;
    logic [pspc_pkg::REG_IDX_W-1:0] w_idx;
    logic [pspc_pkg::SAMPLE_W-1:0]  w_v12;
    logic [pspc_pkg::FRAC_W-1:0]    w_v8;
    logic                           w_wr;

    assign w_idx = i_paddr[pspc_pkg::PADDR_W-1:2];
    assign w_v12 = i_pwdata[pspc_pkg::SAMPLE_W-1:0];
    assign w_v8  = i_pwdata[pspc_pkg::FRAC_W-1:0];
    assign w_wr  = i_psel & i_penable & i_pwrite;

    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            case (w_idx)
                pspc_pkg::REG_THR_SPIKE:   n_cfg.throttle_spike_limit   = w_v12;
                pspc_pkg::REG_BRK_SPIKE:   n_cfg.brake_spike_limit      = w_v12;
                pspc_pkg::REG_THR_PRESSED: n_cfg.throttle_pressed_level = w_v12;
                pspc_pkg::REG_BRK_PRESSED: n_cfg.brake_pressed_level    = w_v12;
                pspc_pkg::REG_THR_FRAC:    n_cfg.throttle_mismatch_frac = w_v8;
                pspc_pkg::REG_BRK_FRAC:    n_cfg.brake_mismatch_frac    = w_v8;
                pspc_pkg::REG_OVL_THR:     n_cfg.overlap_throttle_level = w_v12;
                pspc_pkg::REG_OVL_BRK:     n_cfg.overlap_brake_level    = w_v12;
                default:                   n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.throttle_spike_limit   <= pspc_pkg::RST_THR_SPIKE;
            r_cfg.brake_spike_limit      <= pspc_pkg::RST_BRK_SPIKE;
            r_cfg.throttle_pressed_level <= pspc_pkg::RST_THR_PRESSED;
            r_cfg.brake_pressed_level    <= pspc_pkg::RST_BRK_PRESSED;
            r_cfg.throttle_mismatch_frac <= pspc_pkg::RST_THR_FRAC;
            r_cfg.brake_mismatch_frac    <= pspc_pkg::RST_BRK_FRAC;
            r_cfg.overlap_throttle_level <= pspc_pkg::RST_OVL_THR;
            r_cfg.overlap_brake_level    <= pspc_pkg::RST_OVL_BRK;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        case (w_idx)
            pspc_pkg::REG_THR_SPIKE:   o_prdata = {20'd0, r_cfg.throttle_spike_limit};
            pspc_pkg::REG_BRK_SPIKE:   o_prdata = {20'd0, r_cfg.brake_spike_limit};
            pspc_pkg::REG_THR_PRESSED: o_prdata = {20'd0, r_cfg.throttle_pressed_level};
            pspc_pkg::REG_BRK_PRESSED: o_prdata = {20'd0, r_cfg.brake_pressed_level};
            pspc_pkg::REG_THR_FRAC:    o_prdata = {24'd0, r_cfg.throttle_mismatch_frac};
            pspc_pkg::REG_BRK_FRAC:    o_prdata = {24'd0, r_cfg.brake_mismatch_frac};
            pspc_pkg::REG_OVL_THR:     o_prdata = {20'd0, r_cfg.overlap_throttle_level};
            pspc_pkg::REG_OVL_BRK:     o_prdata = {20'd0, r_cfg.overlap_brake_level};
            default:                   o_prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

[rtl/pspc_front.sv]
// Front end: accepts sample sets, spike-filters each sample channel (BSPD bit passes through), pushes to the queue.
module pspc_front #(
    parameter int unsigned CURRENT_SPIKE_LIMIT = 400
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [pspc_pkg::IN_TDATA_W-1:0] i_data,
    input  pspc_pkg::t_cfg                  i_cfg,
    input  pspc_pkg::t_qstat                i_qstat,
    output logic                            o_push,
    output pspc_pkg::t_filt                 o_filt
);

    localparam logic [pspc_pkg::SAMPLE_W-1:0] CurLimit =
        pspc_pkg::SAMPLE_W'(CURRENT_SPIKE_LIMIT);

    // previous raw samples
    logic [pspc_pkg::SAMPLE_W-1:0] r_last_ta, r_last_tb, r_last_ba, r_last_bb, r_last_cur;
    pspc_pkg::t_filt w_raw;

    function automatic logic [pspc_pkg::SAMPLE_W-1:0] despike(
        input logic [pspc_pkg::SAMPLE_W-1:0] raw,
        input logic [pspc_pkg::SAMPLE_W-1:0] last,
        input logic [pspc_pkg::SAMPLE_W-1:0] limit
    );
        return (pspc_pkg::abs_diff(raw, last) > limit) ? last : raw;
    endfunction

    assign w_raw   = i_data[$bits(pspc_pkg::t_filt)-1:0];
    assign o_ready = !i_qstat.full;
    assign o_push  = i_valid & o_ready;

    assign o_filt.ta   = despike(w_raw.ta, r_last_ta, i_cfg.throttle_spike_limit);
    assign o_filt.tb   = despike(w_raw.tb, r_last_tb, i_cfg.throttle_spike_limit);
    assign o_filt.ba   = despike(w_raw.ba, r_last_ba, i_cfg.brake_spike_limit);
    assign o_filt.bb   = despike(w_raw.bb, r_last_bb, i_cfg.brake_spike_limit);
    assign o_filt.cur  = despike(w_raw.cur, r_last_cur, CurLimit);
    assign o_filt.bspd = w_raw.bspd;

    // raw sample of each accepted item is stored, filtered or not
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_ta  <= '0;
            r_last_tb  <= '0;
            r_last_ba  <= '0;
            r_last_bb  <= '0;
            r_last_cur <= '0;
        end else if (o_push) begin
            r_last_ta  <= w_raw.ta;
            r_last_tb  <= w_raw.tb;
            r_last_ba  <= w_raw.ba;
            r_last_bb  <= w_raw.bb;
            r_last_cur <= w_raw.cur;
        end
    end

endmodule

[rtl/pspc_queue.sv]
// Two-entry queue of filtered sample sets between front and back.
module pspc_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  pspc_pkg::t_filt  i_filt,
    input  logic             i_pop,
    output pspc_pkg::t_filt  o_filt,
    output pspc_pkg::t_qstat o_qstat
);

    localparam int unsigned Depth = 2;
    localparam int unsigned PtrW  = $clog2(Depth);
    localparam int unsigned CntW  = $clog2(Depth + 1);

    pspc_pkg::t_filt r_slot [Depth];
    logic [PtrW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CntW-1:0] r_count;
    logic            w_push, w_pop;

    assign o_qstat.full  = (r_count == CntW'(Depth));
    assign o_qstat.empty = (r_count == '0);
    assign w_push = i_push & !o_qstat.full;
    assign w_pop  = i_pop & !o_qstat.empty;
    assign o_filt = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr_ptr] <= i_filt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PtrW'(Depth - 1)) ? '0 : r_wr_ptr + PtrW'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PtrW'(Depth - 1)) ? '0 : r_rd_ptr + PtrW'(1);
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + CntW'(1);
                2'b01:   r_count <= r_count - CntW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

[rtl/pspc_back.sv]
// Back end: averages, pressed/mismatch/overlap flags, fault summary, registered result output.
module pspc_back (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  pspc_pkg::t_cfg                   i_cfg,
    input  pspc_pkg::t_filt                  i_filt,
    input  logic                             i_avail,
    output logic                             o_pop,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [pspc_pkg::OUT_TDATA_W-1:0] o_data
);

    localparam int unsigned SW = pspc_pkg::SAMPLE_W;
    localparam int unsigned PW = pspc_pkg::PROD_W;

    logic            r_valid;
    pspc_pkg::t_result r_res;
    pspc_pkg::t_result n_res;
    logic [SW:0]     w_tsum, w_bsum;
    logic            w_tmis, w_bmis, w_ovl;

    // d*256 > frac*reading for either reading; no division needed
    function automatic logic mismatch(
        input logic [SW-1:0]                    x,
        input logic [SW-1:0]                    y,
        input logic [pspc_pkg::FRAC_W-1:0]      frac
    );
        logic [PW-1:0] d;
        logic [PW-1:0] px;
        logic [PW-1:0] py;
        d  = {pspc_pkg::abs_diff(x, y), 8'd0};
        px = PW'(frac) * PW'(x);
        py = PW'(frac) * PW'(y);
        return (d > px) || (d > py);
    endfunction

    assign w_tsum = {1'b0, i_filt.ta} + {1'b0, i_filt.tb};
    assign w_bsum = {1'b0, i_filt.ba} + {1'b0, i_filt.bb};
    assign w_tmis = mismatch(i_filt.ta, i_filt.tb, i_cfg.throttle_mismatch_frac);
    assign w_bmis = mismatch(i_filt.ba, i_filt.bb, i_cfg.brake_mismatch_frac);
    assign w_ovl  = ((i_filt.ta > i_cfg.overlap_throttle_level) ||
                     (i_filt.tb > i_cfg.overlap_throttle_level)) &&
                    ((i_filt.ba > i_cfg.overlap_brake_level) ||
                     (i_filt.bb > i_cfg.overlap_brake_level));

    always_comb begin
        n_res.throttle_avg      = w_tsum[SW:1];
        n_res.brake_avg         = w_bsum[SW:1];
        n_res.current_out       = i_filt.cur;
        n_res.throttle_pressed  = (w_tsum[SW:1] > i_cfg.throttle_pressed_level);
        n_res.brake_pressed     = (w_bsum[SW:1] > i_cfg.brake_pressed_level);
        n_res.throttle_mismatch = w_tmis;
        n_res.brake_mismatch    = w_bmis;
        n_res.bspd_fault        = i_filt.bspd;
        n_res.overlap_fault     = w_ovl;
        n_res.fault_recoverable = w_tmis | w_bmis | w_ovl;
        n_res.fault_latching    = i_filt.bspd;
    end

    // load the output register from the queue head when it is empty or being drained
    assign o_pop = i_avail & (!r_valid | i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_res <= n_res;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = {{(pspc_pkg::OUT_TDATA_W - $bits(pspc_pkg::t_result)){1'b0}}, r_res};

endmodule

[rtl/pspc_checker.sv]
// Port-level checks for the plausibility block, bound to the top level.
module pspc_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [pspc_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    // an accepted item leads to a valid output once it has passed the queue into the output register
    a_item_reaches_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |-> ##2 m_axis_tvalid)
        else $error("accepted item did not reach the output");

    // input back-pressure only while a result is waiting
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with output empty");

    // fault combination on the result
    a_fault_combine: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[42] == (m_axis_tdata[38] | m_axis_tdata[39] |
                                                m_axis_tdata[41]))
                          && (m_axis_tdata[43] == m_axis_tdata[40]))
        else $error("fault summary bits inconsistent");

    // waiting result holds its value
    a_result_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

endmodule

bind pedal_sensor_plausibility_top pspc_checker u_pspc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
